### sv/hbsa_pkg.sv
package hbsa_pkg;

	// Default sizes of the allocator.
	localparam int unsigned NUM_SLOTS_DEF      = 4096;
	localparam int unsigned MAX_SLOT_BYTES_DEF = 256;

	// Fixed geometry of the bitmap levels.
	localparam int unsigned WORD_BITS = 64;
	localparam int unsigned MAP_BITS  = 32;
	localparam int unsigned POS_W     = $clog2(WORD_BITS);
	localparam int unsigned MAP_POS_W = $clog2(MAP_BITS);

	// Field widths of the request and result channels.
	localparam int unsigned CMD_W  = 2;
	localparam int unsigned IDX_W  = 12;
	localparam int unsigned OFFS_W = 20;

	// Configuration port geometry.
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic        REG_SLOT_BYTES = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_ACCESS = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUM,
		ST_WORD,
		ST_SLOT,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_ACCESS,
		ST_RESP
	} state_t;

	// Result of the shared trailing-zero count.
	typedef struct packed {
		logic             zero;
		logic [POS_W-1:0] pos;
	} ctz_res_t;

endpackage

### sv/hbsa_ram.sv
module hbsa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/hbsa_ctz.sv
module hbsa_ctz (
	input  logic [hbsa_pkg::WORD_BITS-1:0] vec,
	output hbsa_pkg::ctz_res_t             res
);

	import hbsa_pkg::*;

	// Priority encoder for the lowest set bit; an all-zero word gives the top position.
	always_comb begin
		res.zero = (vec == '0);
		res.pos  = POS_W'(WORD_BITS - 1);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (vec[i]) begin
				res.pos = POS_W'(i);
			end
		end
	end

endmodule

### sv/hbsa_cfg.sv
module hbsa_cfg #(
	parameter int unsigned MAX_SLOT_BYTES = hbsa_pkg::MAX_SLOT_BYTES_DEF,
	parameter int unsigned SB_W           = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hbsa_pkg::PADDR_W-1:0]  paddr,
	input  logic [hbsa_pkg::PDATA_W-1:0]  pwdata,
	output logic [hbsa_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [SB_W-1:0]               slot_bytes
);

	import hbsa_pkg::*;

	logic          reg_sel;
	logic          wr_en;
	logic [SB_W-1:0] slot_bytes_q;

	assign reg_sel = (paddr[PADDR_W-1] == REG_SLOT_BYTES);
	assign wr_en   = psel && penable && pwrite && reg_sel && (pwdata <= PDATA_W'(MAX_SLOT_BYTES));

	// Slot size register; values above the maximum are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= SB_W'(1);
		end else if (wr_en) begin
			slot_bytes_q <= SB_W'(pwdata);
		end
	end

	assign prdata     = reg_sel ? PDATA_W'(slot_bytes_q) : '0;
	assign pready     = 1'b1;
	assign slot_bytes = slot_bytes_q;

endmodule

### sv/hierarchical_bitmap_slot_allocator.sv
// Channel   Handshake              Payload
// request   in_valid / in_stall    command, slot_id
// result    out_valid / out_stall  granted_slot, now_full, now_empty, byte_offset, failed
// config    APB (psel, penable)    paddr, pwdata, prdata
//
// After the idle step takes a request: allocate searches the summary, word and slot maps,
// free reads then writes, access computes the offset, and an unknown command or an allocation
// failing at the summary or word map goes straight to the response. The three trailing-zero
// searches share one encoder in turn, one level per cycle. After reset a clearing pass writes
// NUM_SLOTS/64 slot-bitmap words with in_stall high; configuration writes are taken throughout.
// A held result keeps the block in its final step, with in_stall high, until it moves out.
module hierarchical_bitmap_slot_allocator #(
	parameter int unsigned NUM_SLOTS      = hbsa_pkg::NUM_SLOTS_DEF,
	parameter int unsigned MAX_SLOT_BYTES = hbsa_pkg::MAX_SLOT_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hbsa_pkg::CMD_W-1:0]    command,
	input  logic [hbsa_pkg::IDX_W-1:0]    slot_id,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hbsa_pkg::IDX_W-1:0]    granted_slot,
	output logic                          now_full,
	output logic                          now_empty,
	output logic [hbsa_pkg::OFFS_W-1:0]   byte_offset,
	output logic                          failed,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hbsa_pkg::PADDR_W-1:0]  paddr,
	input  logic [hbsa_pkg::PDATA_W-1:0]  pwdata,
	output logic [hbsa_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	import hbsa_pkg::*;

	localparam int unsigned SLOT_WORDS = NUM_SLOTS / WORD_BITS;
	localparam int unsigned SW_W       = SLOT_WORDS > 1 ? $clog2(SLOT_WORDS) : 1;
	localparam int unsigned MAP_WORDS  = (SLOT_WORDS + MAP_BITS - 1) / MAP_BITS;
	localparam int unsigned MW_W       = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned CNT_W      = $clog2(NUM_SLOTS + 1);
	localparam int unsigned SB_W       = $clog2(MAX_SLOT_BYTES + 1);
	localparam int unsigned PROD_W     = IDX_W + SB_W;
	localparam int unsigned SWA_W      = MW_W + MAP_POS_W;

	// Reset value of one word-bitmap word: only existing slot words are marked free.
	function automatic logic [MAP_BITS-1:0] word_init(input int i);
		int unsigned left;
		left = SLOT_WORDS - 32'(i) * MAP_BITS;
		word_init = (left >= MAP_BITS) ? '1 : MAP_BITS'((64'd1 << left) - 64'd1);
	endfunction

	state_t state_q, state_d;

	logic [IDX_W-1:0]     idx_q;
	logic [MW_W-1:0]      s_q;
	logic [MAP_POS_W-1:0] w_q;
	logic [SW_W-1:0]      clr_q;
	logic [MAP_BITS-1:0]  word_free_q [MAP_WORDS];
	logic [MAP_WORDS-1:0] summary_q;
	logic [CNT_W-1:0]     count_q;

	logic [IDX_W-1:0]  res_slot_q;
	logic              res_full_q;
	logic              res_empty_q;
	logic [OFFS_W-1:0] res_offs_q;
	logic              res_fail_q;

	logic              out_valid_q;
	logic [IDX_W-1:0]  granted_slot_q;
	logic              now_full_q;
	logic              now_empty_q;
	logic [OFFS_W-1:0] byte_offset_q;
	logic              failed_q;

	logic [SB_W-1:0]      slot_bytes;
	logic [WORD_BITS-1:0] ctz_in;
	ctz_res_t             ctz_res;
	logic                 alloc_fail;
	logic                 resp_go;

	logic                 ram_we;
	logic [SW_W-1:0]      ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [SW_W-1:0]      ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic [MAP_BITS-1:0]  word_sel;
	logic [SWA_W-1:0]     sw_next;
	logic [SWA_W-1:0]     sw_alloc;
	logic [WORD_BITS-1:0] slot_new;
	logic [MAP_BITS-1:0]  word_after;
	logic [MAP_WORDS-1:0] summ_after;
	logic                 idx_ok;
	logic [SW_W-1:0]      f_sw;
	logic [MW_W-1:0]      f_ww;
	logic [MAP_POS_W-1:0] f_bit;
	logic [CNT_W-1:0]     cnt_dec;
	logic [PROD_W-1:0]    prod;

	hbsa_cfg #(
		.MAX_SLOT_BYTES (MAX_SLOT_BYTES),
		.SB_W           (SB_W)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.slot_bytes (slot_bytes)
	);

	hbsa_ctz u_ctz (
		.vec (ctz_in),
		.res (ctz_res)
	);

	hbsa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (SLOT_WORDS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Address and update arithmetic for the three bitmap levels.
	assign word_sel   = word_free_q[s_q];
	assign sw_next    = {s_q, ctz_res.pos[MAP_POS_W-1:0]};
	assign sw_alloc   = {s_q, w_q};
	assign slot_new   = ram_rdata & ~(WORD_BITS'(1) << ctz_res.pos);
	assign word_after = (slot_new == '0) ? (word_sel & ~(MAP_BITS'(1) << w_q)) : word_sel;
	assign summ_after = (word_after == '0) ? (summary_q & ~(MAP_WORDS'(1) << s_q)) : summary_q;
	assign idx_ok     = 32'(idx_q) < NUM_SLOTS;
	assign f_sw       = SW_W'(idx_q >> POS_W);
	assign f_ww       = MW_W'(idx_q >> (POS_W + MAP_POS_W));
	assign f_bit      = MAP_POS_W'(idx_q >> POS_W);
	assign cnt_dec    = (count_q != '0) ? count_q - 1'b1 : count_q;
	assign prod       = PROD_W'(idx_q) * PROD_W'(slot_bytes);
	assign resp_go    = !out_valid_q || !out_stall;

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == SW_W'(SLOT_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (command)
						CMD_ALLOC:  state_d = ST_SUM;
						CMD_FREE:   state_d = ST_FREE_RD;
						CMD_ACCESS: state_d = ST_ACCESS;
						default:    state_d = ST_RESP;
					endcase
				end
			end
			ST_SUM:     state_d = alloc_fail ? ST_RESP : ST_WORD;
			ST_WORD:    state_d = alloc_fail ? ST_RESP : ST_SLOT;
			ST_SLOT:    state_d = ST_RESP;
			ST_FREE_RD: state_d = ST_FREE_WR;
			ST_FREE_WR: state_d = ST_RESP;
			ST_ACCESS:  state_d = ST_RESP;
			ST_RESP: begin
				if (resp_go) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Sequencer: encoder input, failure checks and slot-bitmap port controls.
	always_comb begin
		ctz_in     = ram_rdata;
		alloc_fail = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = f_sw;
		ram_wdata  = ram_rdata | (WORD_BITS'(1) << idx_q[POS_W-1:0]);
		ram_re     = 1'b0;
		ram_raddr  = f_sw;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '1;
			end
			ST_SUM: begin
				ctz_in     = WORD_BITS'(summary_q);
				alloc_fail = ctz_res.zero || (32'(ctz_res.pos) >= MAP_WORDS);
			end
			ST_WORD: begin
				ctz_in     = WORD_BITS'(word_sel);
				alloc_fail = ctz_res.zero || (32'(sw_next) >= SLOT_WORDS);
				ram_re     = 1'b1;
				ram_raddr  = SW_W'(sw_next);
			end
			ST_SLOT: begin
				alloc_fail = ctz_res.zero;
				ram_we     = !ctz_res.zero;
				ram_waddr  = SW_W'(sw_alloc);
				ram_wdata  = slot_new;
			end
			ST_FREE_RD: begin
				ram_re = 1'b1;
			end
			ST_FREE_WR: begin
				ram_we = idx_ok;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control state, bitmap levels and use count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			summary_q   <= '1;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAP_WORDS; i++) begin
				word_free_q[i] <= word_init(i);
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_SLOT && !ctz_res.zero) begin
				word_free_q[s_q] <= word_after;
				summary_q        <= summ_after;
				if (count_q < CNT_W'(NUM_SLOTS)) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (state_q == ST_FREE_WR && idx_ok) begin
				word_free_q[f_ww] <= word_free_q[f_ww] | (MAP_BITS'(1) << f_bit);
				summary_q         <= summary_q | (MAP_WORDS'(1) << f_ww);
				count_q           <= cnt_dec;
			end
			if (state_q == ST_RESP && resp_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, search positions and result fields.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					idx_q       <= slot_id;
					res_slot_q  <= '0;
					res_full_q  <= 1'b0;
					res_empty_q <= 1'b0;
					res_offs_q  <= '0;
					res_fail_q  <= 1'b0;
				end
			end
			ST_SUM, ST_WORD, ST_SLOT: begin
				if (state_q == ST_SUM) begin
					s_q <= MW_W'(ctz_res.pos);
				end
				if (state_q == ST_WORD) begin
					w_q <= ctz_res.pos[MAP_POS_W-1:0];
				end
				if (alloc_fail) begin
					res_full_q <= 1'b1;
					res_fail_q <= 1'b1;
				end else if (state_q == ST_SLOT) begin
					res_slot_q <= IDX_W'({sw_alloc, ctz_res.pos});
					res_full_q <= (summ_after == '0);
				end
			end
			ST_FREE_WR: begin
				if (idx_ok) begin
					res_empty_q <= (cnt_dec == '0);
				end
			end
			ST_ACCESS: begin
				if (idx_ok) begin
					res_offs_q <= OFFS_W'(prod);
				end
			end
			ST_RESP: begin
				if (resp_go) begin
					granted_slot_q <= res_slot_q;
					now_full_q     <= res_full_q;
					now_empty_q    <= res_empty_q;
					byte_offset_q  <= res_offs_q;
					failed_q       <= res_fail_q;
				end
			end
			default: begin
				res_fail_q <= res_fail_q;
			end
		endcase
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign granted_slot = granted_slot_q;
	assign now_full     = now_full_q;
	assign now_empty    = now_empty_q;
	assign byte_offset  = byte_offset_q;
	assign failed       = failed_q;

`ifndef SYNTHESIS
	// A new result appears only from the response step.
	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_RESP)
		else $error("result presented outside the response step");

	// An empty summary must make the allocation fail.
	a_empty_summary_fails: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM && summary_q == '0) |=> (res_fail_q && state_q == ST_RESP))
		else $error("allocation with no free slot did not fail");

	// A failed allocation reports full and grants nothing.
	a_fail_reports_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && failed_q) |-> (now_full_q && granted_slot_q == '0))
		else $error("failed allocation without full flag or with a grant");

	// The use count never passes the number of slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SLOT) |=> (count_q <= CNT_W'(NUM_SLOTS)))
		else $error("use count beyond the number of slots");
`endif

endmodule
